@@ hw/rtl/brtd_pkg.sv @@
// brtd_pkg: types, constants and the character map of the radix text decoder
// used by all brtd modules; no dependencies
`timescale 1ns / 1ps

package brtd_pkg;

    localparam logic [1:0] MODE_B16 = 2'd0;
    localparam logic [1:0] MODE_B32 = 2'd1;
    localparam logic [1:0] MODE_B64 = 2'd2;
    localparam logic [1:0] MODE_RESET = MODE_B64;

    localparam int SYM_DEPTH = 8;
    localparam int SYM_W = 6;
    localparam int POS_W = 3;
    localparam logic [3:0] NO_PAD = 4'd8;
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    localparam int BLK_BITS = 40;
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [BLK_BITS-1:0] data;
        logic [2:0]          nbytes;
        logic                bad;
    } blk_t;

    typedef struct packed {
        logic known;
        logic [SYM_W-1:0] sym;
    } sym_t;

    function automatic sym_t decode_char(input logic [1:0] mode, input logic [7:0] c);
        sym_t r;
        r.known = 1'b1;
        r.sym = '0;
        case (mode)
            MODE_B16: begin
                if (c >= 8'h30 && c <= 8'h39) r.sym = 6'(c - 8'h30);
                else if (c >= 8'h41 && c <= 8'h46) r.sym = 6'(c - 8'h41 + 8'd10);
                else if (c >= 8'h61 && c <= 8'h66) r.sym = 6'(c - 8'h61 + 8'd10);
                else r.known = 1'b0;
            end
            MODE_B32: begin
                if (c >= 8'h41 && c <= 8'h5A) r.sym = 6'(c - 8'h41);
                else if (c >= 8'h61 && c <= 8'h7A) r.sym = 6'(c - 8'h61);
                else if (c >= 8'h32 && c <= 8'h37) r.sym = 6'(c - 8'h32 + 8'd26);
                else r.known = 1'b0;
            end
            default: begin
                if (c >= 8'h41 && c <= 8'h5A) r.sym = 6'(c - 8'h41);
                else if (c >= 8'h61 && c <= 8'h7A) r.sym = 6'(c - 8'h61 + 8'd26);
                else if (c >= 8'h30 && c <= 8'h39) r.sym = 6'(c - 8'h30 + 8'd52);
                else if (c == 8'h2B) r.sym = 6'd62;
                else if (c == 8'h2F) r.sym = 6'd63;
                else r.known = 1'b0;
            end
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/brtd_front.sv @@
// brtd_front: accepts characters, maps them to symbols and collects blocks
// depends on brtd_pkg; pushes finished blocks into brtd_queue
`timescale 1ns / 1ps

module brtd_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_in_char,
    input  logic               q_full,
    output logic               q_push,
    output brtd_pkg::blk_t     q_data
);
    import brtd_pkg::*;

    logic [1:0]       mode_reg;
    logic [SYM_W-1:0] sym_reg [SYM_DEPTH];
    logic [POS_W-1:0] count_reg, count_next;
    logic [3:0]       pad_reg, pad_next;
    logic             bad_reg, bad_next;

    sym_t             dec;
    logic             is_pad;
    logic [SYM_W-1:0] sym_new;
    logic [2:0]       bits;
    logic [POS_W-1:0] last_pos;
    logic [2:0]       full_bytes;
    logic             accept, complete;
    logic [SYM_W-1:0] view [SYM_DEPTH];
    logic [5:0]       pad_bits;
    logic [2:0]       nbytes;

    assign s_ready = !q_full;
    assign accept = s_valid && s_ready;
    assign dec = decode_char(mode_reg, s_in_char);
    assign is_pad = (s_in_char == PAD_CHAR);
    assign sym_new = (is_pad || !dec.known) ? '0 : dec.sym;

    always_comb begin
        case (mode_reg)
            MODE_B16: begin
                bits = 3'd4; last_pos = 3'd1; full_bytes = 3'd1;
            end
            MODE_B32: begin
                bits = 3'd5; last_pos = 3'd7; full_bytes = 3'd5;
            end
            default: begin
                bits = 3'd6; last_pos = 3'd3; full_bytes = 3'd3;
            end
        endcase
    end

    assign complete = (count_reg == last_pos);

    always_comb begin
        for (int i = 0; i < SYM_DEPTH; i++) begin
            view[i] = (count_reg == POS_W'(i)) ? sym_new : sym_reg[i];
        end
    end

    always_comb begin
        pad_next = pad_reg;
        if (is_pad && pad_reg == NO_PAD) pad_next = {1'b0, count_reg};
        bad_next = bad_reg | (!is_pad && !dec.known);
        count_next = count_reg + 1'b1;
    end

    assign pad_bits = 6'(pad_next[2:0]) * 6'(bits);

    always_comb begin
        nbytes = full_bytes;
        if (pad_next != NO_PAD && pad_bits[5:3] < full_bytes) nbytes = pad_bits[5:3];
    end

    always_comb begin
        q_data.nbytes = nbytes;
        q_data.bad = bad_next;
        case (mode_reg)
            MODE_B16: q_data.data = {view[0][3:0], view[1][3:0], 32'd0};
            MODE_B32: q_data.data = {view[0][4:0], view[1][4:0], view[2][4:0], view[3][4:0],
                                     view[4][4:0], view[5][4:0], view[6][4:0], view[7][4:0]};
            default:  q_data.data = {view[0], view[1], view[2], view[3], 16'd0};
        endcase
    end

    assign q_push = accept && complete && (nbytes != 3'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_RESET;
            count_reg <= '0;
            pad_reg <= NO_PAD;
            bad_reg <= 1'b0;
        end else if (cfg_we) begin
            mode_reg <= cfg_wdata;
            count_reg <= '0;
            pad_reg <= NO_PAD;
            bad_reg <= 1'b0;
        end else if (accept) begin
            if (complete) begin
                count_reg <= '0;
                pad_reg <= NO_PAD;
                bad_reg <= 1'b0;
            end else begin
                count_reg <= count_next;
                pad_reg <= pad_next;
                bad_reg <= bad_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) sym_reg[count_reg] <= sym_new;
    end

endmodule

@@ hw/rtl/brtd_queue.sv @@
// brtd_queue: short block queue between front and back
// depends on brtd_pkg for the block type and depth
`timescale 1ns / 1ps

module brtd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  brtd_pkg::blk_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output brtd_pkg::blk_t pop_data
);
    import brtd_pkg::*;

    blk_t              ent_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign full = (cnt_reg == QCNT_W'(QDEPTH));
    assign empty = (cnt_reg == '0);
    assign pop_data = ent_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) cnt_next = cnt_reg + 1'b1;
        else if (pop && !push) cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop) rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) ent_reg[wr_ptr_reg] <= push_data;
    end

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full)) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty)) else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= QCNT_W'(QDEPTH)) else $error("queue count out of range");
    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (empty || full) |-> (wr_ptr_reg == rd_ptr_reg)) else $error("queue pointers disagree");

endmodule

@@ hw/rtl/brtd_back.sv @@
// brtd_back: splits queued blocks into bytes, one word per cycle while m_ready allows
// depends on brtd_pkg; drives the registered result channel
`timescale 1ns / 1ps

module brtd_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_empty,
    input  brtd_pkg::blk_t q_data,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [7:0]     m_out_byte,
    output logic           m_last_of_block,
    output logic           m_bad_char
);
    import brtd_pkg::*;

    logic [2:0] idx_reg;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg, bad_reg;
    logic       load, is_last;
    logic [7:0] sel_byte;

    assign m_valid = valid_reg;
    assign m_out_byte = byte_reg;
    assign m_last_of_block = last_reg;
    assign m_bad_char = bad_reg;

    assign load = !q_empty && (!valid_reg || m_ready);
    assign is_last = (idx_reg + 1'b1 == q_data.nbytes);
    assign q_pop = load && is_last;

    always_comb begin
        case (idx_reg)
            3'd0: sel_byte = q_data.data[39:32];
            3'd1: sel_byte = q_data.data[31:24];
            3'd2: sel_byte = q_data.data[23:16];
            3'd3: sel_byte = q_data.data[15:8];
            3'd4: sel_byte = q_data.data[7:0];
            default: sel_byte = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg <= '0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                idx_reg <= is_last ? 3'd0 : idx_reg + 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= sel_byte;
            last_reg <= is_last;
            bad_reg <= q_data.bad;
        end
    end

endmodule

@@ hw/rtl/base_radix_text_decoder.sv @@
// base_radix_text_decoder: Base16 / Base32 / Base64 streaming text decoder
// depends on brtd_pkg, brtd_front, brtd_queue, brtd_back
//
// input: one text character per word on s_in_char (valid/ready)
// output: decoded bytes on m_out_byte, m_last_of_block on the final byte
// of each block, m_bad_char when the block held a character outside the alphabet
// cfg_we/cfg_wdata set the alphabet: 0 base16, 1 base32, 2 or 3 base64;
// a write drops any partly collected block
// one character is accepted per cycle while s_ready is high; the front collects
// a block of 2, 8 or 4 characters and queues it, the back emits one byte per
// cycle while m_ready allows; a block is queued before its bytes are registered
// padding cuts a block short; a block that keeps no byte gives no word
// reset: base64, no block held, queue and output empty
// when m_ready is low the output word holds; characters keep flowing until
// the two-entry block queue fills, then s_ready drops
`timescale 1ns / 1ps

module base_radix_text_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_char,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last_of_block,
    output logic       m_bad_char
);
    import brtd_pkg::*;

    logic q_full, q_empty, q_push, q_pop;
    blk_t push_data, pop_data;

    brtd_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_in_char(s_in_char),
        .q_full(q_full), .q_push(q_push), .q_data(push_data)
    );

    brtd_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(q_push), .push_data(push_data), .full(q_full),
        .pop(q_pop), .empty(q_empty), .pop_data(pop_data)
    );

    brtd_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_empty(q_empty), .q_data(pop_data), .q_pop(q_pop),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_byte(m_out_byte),
        .m_last_of_block(m_last_of_block), .m_bad_char(m_bad_char)
    );

endmodule
